// ===== src/eci_pkg.sv =====
// ----------------------------------------------------------------------------
// eci_pkg: shared types and constants for the easing curve interpolator
// Word layouts, curve mode codes, curve kind codes and queue sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package eci_pkg;

	// number formats
	localparam int FRAC_BITS   = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int POS_W       = FRAC_BITS + 1;
	localparam int HI_W        = VALUE_WIDTH + 1 - FRAC_BITS;

	localparam logic [POS_W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [POS_W-1:0] HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};
	localparam logic [POS_W:0]   TWO  = {1'b1, {(FRAC_BITS+1){1'b0}}};

	// power evaluation: up to seven truncating multiplies (eighth power)
	localparam int MUL_STAGES = 7;
	localparam int MULT_W     = 3;

	// curve mode codes
	localparam logic [3:0] MODE_EASE_IN      = 4'd0;
	localparam logic [3:0] MODE_EASE_OUT     = 4'd1;
	localparam logic [3:0] MODE_FLAT         = 4'd2;
	localparam logic [3:0] MODE_LINEAR       = 4'd3;
	localparam logic [3:0] MODE_SHARP_IN     = 4'd4;
	localparam logic [3:0] MODE_SHARP_OUT    = 4'd5;
	localparam logic [3:0] MODE_SHARP_SMOOTH = 4'd6;
	localparam logic [3:0] MODE_SMOOTH       = 4'd7;
	localparam logic [3:0] MODE_SOFT_IN      = 4'd8;
	localparam logic [3:0] MODE_SOFT_OUT     = 4'd9;
	localparam logic [3:0] MODE_SOFT_SMOOTH  = 4'd10;

	// how the power p of the base becomes the curve value
	localparam logic [1:0] KIND_POW      = 2'd0; // p
	localparam logic [1:0] KIND_INV      = 2'd1; // one - p
	localparam logic [1:0] KIND_HALF     = 2'd2; // p / 2
	localparam logic [1:0] KIND_HALF_INV = 2'd3; // (two - p) / 2

	// queue sizes
	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW    = 2;
	localparam int FQ_CW    = 3;
	localparam int OQ_DEPTH = 16;
	localparam int OQ_AW    = 4;
	localparam int OQ_CW    = 5;

	typedef struct packed {
		logic [3:0]             mode;
		logic [POS_W-1:0]       position;
		logic [POS_W-1:0]       weight;
		logic [VALUE_WIDTH-1:0] start_value;
		logic [VALUE_WIDTH-1:0] end_value;
	} eci_in_t;

	typedef struct packed {
		logic [POS_W-1:0]       shaped_position;
		logic [VALUE_WIDTH-1:0] result_value;
	} eci_out_t;

	// classified word handed from front to back
	typedef struct packed {
		logic [1:0]             kind;
		logic [MULT_W-1:0]      mults;
		logic [POS_W-1:0]       base;
		logic [POS_W-1:0]       pos;
		logic [POS_W-1:0]       wt;
		logic [VALUE_WIDTH-1:0] x0;
		logic [VALUE_WIDTH-1:0] x1;
	} eci_item_t;

	// output queue status
	typedef struct packed {
		logic empty;
		logic full;
		logic room;
	} eci_oq_stat_t;

endpackage

`default_nettype wire

// ===== src/eci_front.sv =====
// ----------------------------------------------------------------------------
// eci_front: input stage of the easing curve interpolator
// Saturates position and weight, maps the mode to a power job and queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module eci_front import eci_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire eci_in_t   item,
	output logic           full,
	output logic           head_valid,
	output eci_item_t      head,
	input  wire logic      issue
);

	logic [POS_W-1:0] t_sat;
	logic [POS_W-1:0] w_sat;
	logic [POS_W-1:0] t_inv;
	logic [1:0]       hs_kind;
	logic [POS_W-1:0] hs_base;
	eci_item_t        ent;

	eci_item_t        fq_q [FQ_DEPTH];
	logic [FQ_AW-1:0] wr_ptr_q;
	logic [FQ_AW-1:0] rd_ptr_q;
	logic [FQ_CW-1:0] cnt_q;
	logic             wr_en;

	localparam logic [FQ_CW-1:0] FQ_FULL = FQ_CW'(FQ_DEPTH);

	// saturate and classify
	always_comb begin
		t_sat = (item.position > ONE) ? ONE : item.position;
		w_sat = (item.weight > ONE) ? ONE : item.weight;
		t_inv = ONE - t_sat;
		// two-sided curves: rising half on 2t, falling half on 2 - 2t
		if (t_sat < HALF) begin
			hs_kind = KIND_HALF;
			hs_base = {t_sat[POS_W-2:0], 1'b0};
		end else begin
			hs_kind = KIND_HALF_INV;
			hs_base = {t_inv[POS_W-2:0], 1'b0};
		end
		ent.kind  = KIND_POW;
		ent.mults = '0;
		ent.base  = '0;
		ent.pos   = t_sat;
		ent.wt    = w_sat;
		ent.x0    = item.start_value;
		ent.x1    = item.end_value;
		case (item.mode)
			MODE_EASE_IN: begin
				ent.kind = KIND_INV; ent.mults = 3'd3; ent.base = t_inv;
			end
			MODE_EASE_OUT: begin
				ent.mults = 3'd3; ent.base = t_sat;
			end
			MODE_FLAT: begin
				ent.base = (t_sat == ONE) ? ONE : '0;
			end
			MODE_LINEAR: begin
				ent.base = t_sat;
			end
			MODE_SHARP_IN: begin
				ent.kind = KIND_INV; ent.mults = 3'd7; ent.base = t_inv;
			end
			MODE_SHARP_OUT: begin
				ent.mults = 3'd5; ent.base = t_sat;
			end
			MODE_SHARP_SMOOTH: begin
				ent.kind = hs_kind; ent.mults = 3'd5; ent.base = hs_base;
			end
			MODE_SMOOTH: begin
				ent.kind = hs_kind; ent.mults = 3'd3; ent.base = hs_base;
			end
			MODE_SOFT_IN: begin
				ent.kind = KIND_INV; ent.mults = 3'd1; ent.base = t_inv;
			end
			MODE_SOFT_OUT: begin
				ent.mults = 3'd1; ent.base = t_sat;
			end
			MODE_SOFT_SMOOTH: begin
				ent.kind = hs_kind; ent.mults = 3'd1; ent.base = hs_base;
			end
			default: begin
				// unknown mode: curve value zero
				ent.base = '0;
			end
		endcase
	end

	// small queue towards the back end
	assign full       = (cnt_q == FQ_FULL);
	assign head_valid = (cnt_q != '0);
	assign head       = fq_q[rd_ptr_q];
	assign wr_en      = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (issue)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({wr_en, issue})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			fq_q[wr_ptr_q] <= ent;
	end

endmodule

`default_nettype wire

// ===== src/eci_back.sv =====
// ----------------------------------------------------------------------------
// eci_back: arithmetic pipeline of the easing curve interpolator
// Power chain, curve select, weight blend and scaled interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module eci_back import eci_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      issue,
	input  wire eci_item_t head,
	output logic           wr_en,
	output eci_out_t       wr_data
);

	typedef struct packed {
		logic [1:0]             kind;
		logic [MULT_W-1:0]      mults;
		logic [POS_W-1:0]       base;
		logic [POS_W-1:0]       pw;
		logic [POS_W-1:0]       pos;
		logic [POS_W-1:0]       wt;
		logic                   neg;
		logic [VALUE_WIDTH:0]   mag;
		logic [VALUE_WIDTH-1:0] x0;
	} eci_pw_t;

	eci_pw_t                 pw_in0;
	logic [VALUE_WIDTH:0]    diff;
	eci_pw_t                 pw_s [MUL_STAGES];
	logic [MUL_STAGES-1:0]   pw_vld_s;
	eci_pw_t                 last;
	logic [POS_W-1:0]        curve;
	logic [POS_W:0]          hi_half;

	logic                    vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13;
	logic [POS_W-1:0]        c_s8;
	logic [POS_W-1:0]        pos_s8, pos_s9, pos_s10;
	logic [POS_W-1:0]        wt_s8, wt_s9;
	logic                    neg_s8, neg_s9, neg_s10, neg_s11, neg_s12, neg_s13;
	logic [VALUE_WIDTH:0]    mag_s8, mag_s9, mag_s10, mag_s11;
	logic [VALUE_WIDTH-1:0]  x0_s8, x0_s9, x0_s10, x0_s11, x0_s12, x0_s13;
	logic                    up_s9, up_s10;
	logic [POS_W-1:0]        d_s9;
	logic [2*POS_W-1:0]      blend_prod;
	logic [POS_W-1:0]        bp_s10;
	logic [POS_W-1:0]        s_s11, s_s12, s_s13;
	logic [HI_W+POS_W-1:0]   hp_s12;
	logic [FRAC_BITS+POS_W-1:0] lp_s12;
	logic [HI_W+POS_W-1:0]   prod_sum;
	logic [VALUE_WIDTH:0]    prod_s13;
	logic [VALUE_WIDTH+1:0]  res;

	// stage 1 input: exact difference and its magnitude
	always_comb begin
		diff = {head.x1[VALUE_WIDTH-1], head.x1} - {head.x0[VALUE_WIDTH-1], head.x0};
		pw_in0.kind  = head.kind;
		pw_in0.mults = head.mults;
		pw_in0.base  = head.base;
		pw_in0.pw    = head.base;
		pw_in0.pos   = head.pos;
		pw_in0.wt    = head.wt;
		pw_in0.neg   = diff[VALUE_WIDTH];
		pw_in0.mag   = diff[VALUE_WIDTH] ? (~diff + 1'b1) : diff;
		pw_in0.x0    = head.x0;
	end

	// power chain: one truncating multiply per stage while steps remain
	for (genvar i = 0; i < MUL_STAGES; i++) begin : g_pow
		eci_pw_t            src;
		logic               src_v;
		eci_pw_t            nxt;
		logic [2*POS_W-1:0] prod;

		if (i == 0) begin : g_head
			assign src   = pw_in0;
			assign src_v = issue;
		end else begin : g_chain
			assign src   = pw_s[i-1];
			assign src_v = pw_vld_s[i-1];
		end

		assign prod = src.pw * src.base;

		always_comb begin
			nxt = src;
			if (src.mults > MULT_W'(i))
				nxt.pw = prod[FRAC_BITS +: POS_W];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				pw_vld_s[i] <= 1'b0;
			else
				pw_vld_s[i] <= src_v;
		end

		always_ff @(posedge clk) begin
			pw_s[i] <= nxt;
		end
	end

	// curve value from the power
	assign last = pw_s[MUL_STAGES-1];

	always_comb begin
		hi_half = TWO - {1'b0, last.pw};
		case (last.kind)
			KIND_POW:      curve = last.pw;
			KIND_INV:      curve = ONE - last.pw;
			KIND_HALF:     curve = last.pw >> 1;
			KIND_HALF_INV: curve = hi_half[POS_W:1];
			default:       curve = last.pw;
		endcase
	end

	assign blend_prod = d_s9 * wt_s9;
	assign prod_sum   = hp_s12 + (HI_W+POS_W)'(lp_s12 >> FRAC_BITS);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else begin
			vld_s8  <= pw_vld_s[MUL_STAGES-1];
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		// s8: curve select
		c_s8   <= curve;
		pos_s8 <= last.pos;
		wt_s8  <= last.wt;
		neg_s8 <= last.neg;
		mag_s8 <= last.mag;
		x0_s8  <= last.x0;
		// s9: distance between curve and linear t
		up_s9  <= (c_s8 >= pos_s8);
		d_s9   <= (c_s8 >= pos_s8) ? (c_s8 - pos_s8) : (pos_s8 - c_s8);
		pos_s9 <= pos_s8;
		wt_s9  <= wt_s8;
		neg_s9 <= neg_s8;
		mag_s9 <= mag_s8;
		x0_s9  <= x0_s8;
		// s10: weighted distance, truncated
		bp_s10  <= blend_prod[FRAC_BITS +: POS_W];
		up_s10  <= up_s9;
		pos_s10 <= pos_s9;
		neg_s10 <= neg_s9;
		mag_s10 <= mag_s9;
		x0_s10  <= x0_s9;
		// s11: shaped position
		s_s11   <= up_s10 ? (pos_s10 + bp_s10) : (pos_s10 - bp_s10);
		neg_s11 <= neg_s10;
		mag_s11 <= mag_s10;
		x0_s11  <= x0_s10;
		// s12: split product of magnitude and shaped position
		hp_s12  <= mag_s11[VALUE_WIDTH:FRAC_BITS] * s_s11;
		lp_s12  <= mag_s11[FRAC_BITS-1:0] * s_s11;
		s_s12   <= s_s11;
		neg_s12 <= neg_s11;
		x0_s12  <= x0_s11;
		// s13: recombine partial products
		prod_s13 <= prod_sum[VALUE_WIDTH:0];
		s_s13    <= s_s12;
		neg_s13  <= neg_s12;
		x0_s13   <= x0_s12;
	end

	// final offset from start value
	always_comb begin
		if (neg_s13)
			res = {{2{x0_s13[VALUE_WIDTH-1]}}, x0_s13} - {1'b0, prod_s13};
		else
			res = {{2{x0_s13[VALUE_WIDTH-1]}}, x0_s13} + {1'b0, prod_s13};
		wr_data.shaped_position = s_s13;
		wr_data.result_value    = res[VALUE_WIDTH-1:0];
	end

	assign wr_en = vld_s13;

endmodule

`default_nettype wire

// ===== src/eci_outq.sv =====
// ----------------------------------------------------------------------------
// eci_outq: result queue of the easing curve interpolator
// Holds finished words and counts credits for words still in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module eci_outq import eci_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      issue,
	input  wire logic      wr_en,
	input  wire eci_out_t  wr_data,
	input  wire logic      pop,
	output eci_out_t       rd_data,
	output eci_oq_stat_t   stat
);

	localparam logic [OQ_CW-1:0] OQ_FULL = OQ_CW'(OQ_DEPTH);

	eci_out_t         oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q;
	logic [OQ_AW-1:0] rd_ptr_q;
	logic [OQ_CW-1:0] cnt_q;
	logic [OQ_CW-1:0] credit_q;
	logic             rd_en;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == OQ_FULL);
	// a word may enter the pipeline only if its result has a slot reserved
	assign stat.room  = (credit_q < OQ_FULL);
	assign rd_en      = pop && !stat.empty;
	assign rd_data    = oq_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			credit_q <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
			// words issued but not yet popped
			case ({issue, rd_en})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			oq_q[wr_ptr_q] <= wr_data;
	end

endmodule

`default_nettype wire

// ===== src/easing_curve_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// easing_curve_interpolator_top: polynomial easing curve interpolator
// Throughput: one word per cycle while result-queue credit remains; the 13-stage
// arithmetic pipeline never stalls, and a 16-word credit on the result queue
// gates issue from the 4-word input queue. Reset (arst_n, async, active low)
// empties both queues and clears the pipeline valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module easing_curve_interpolator_top import eci_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	output logic         full,
	input  wire eci_in_t item,
	output logic         empty,
	input  wire logic    pop,
	output eci_out_t     result
);

	logic         head_valid;
	eci_item_t    head;
	logic         issue;
	logic         wr_en;
	eci_out_t     wr_data;
	eci_oq_stat_t stat;

	// issue when a job waits and its result slot is reserved
	assign issue = head_valid && stat.room;
	assign empty = stat.empty;

	eci_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item       (item),
		.full       (full),
		.head_valid (head_valid),
		.head       (head),
		.issue      (issue)
	);

	eci_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.issue   (issue),
		.head    (head),
		.wr_en   (wr_en),
		.wr_data (wr_data)
	);

	eci_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.issue   (issue),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.pop     (pop),
		.rd_data (result),
		.stat    (stat)
	);

	// credit scheme: the pipeline never writes into a full result queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !stat.full)
		else $error("result queue written while full");

	// pipeline holds fewer words than the credit, so exhausted credit means waiting results
	a_credit_held: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.room |-> !stat.empty)
		else $error("credit exhausted with empty result queue");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for easing_curve_interpolator_top
// A short table of hand-picked words (curve ends, saturation, unknown modes,
// widest value span) runs first, then random words in three pacing phases.
// Every accepted input word queues its expected result (hand-worked or predicted);
// each popped result word is checked field by field against the oldest one queued.
// ----------------------------------------------------------------------------

module testbench;
	import eci_pkg::*;

	localparam int          ITEMS_PER_PHASE = 135;
	localparam int          HOLD_CYCLES     = 150;
	localparam int          DRAIN_CYCLES    = 40;
	localparam int          CYCLE_LIMIT     = 200000;
	localparam logic [63:0] ONE_Q           = 64'(ONE);
	localparam logic [63:0] HALF_Q          = 64'(HALF);

	// one row of the directed table; known marks rows with a hand-worked answer
	typedef struct {
		logic [3:0]             mode;
		logic [POS_W-1:0]       pos;
		logic [POS_W-1:0]       wt;
		logic [VALUE_WIDTH-1:0] x0;
		logic [VALUE_WIDTH-1:0] x1;
		bit                     known;
		logic [POS_W-1:0]       sp;
		logic [VALUE_WIDTH-1:0] rv;
	} dir_row_t;

	localparam int DIR_ROWS = 22;

	dir_row_t dir_tab [DIR_ROWS] = '{
		// linear curve ends and saturation
		'{MODE_LINEAR, 17'h00000, 17'h10000, 32'h00010000, 32'h00050000, 1'b1,
			17'h00000, 32'h00010000},
		'{MODE_LINEAR, 17'h10000, 17'h10000, 32'h00010000, 32'h00050000, 1'b1,
			17'h10000, 32'h00050000},
		'{MODE_LINEAR, 17'h1ffff, 17'h1ffff, 32'h80000000, 32'h7fffffff, 1'b1,
			17'h10000, 32'h7fffffff},
		'{MODE_LINEAR, 17'h10000, 17'h10000, 32'h7fffffff, 32'h80000000, 1'b1,
			17'h10000, 32'h80000000},
		// flat step just below and at one
		'{MODE_FLAT, 17'h0ffff, 17'h10000, 32'hfff00000, 32'h00200000, 1'b1,
			17'h00000, 32'hfff00000},
		'{MODE_FLAT, 17'h10000, 17'h10000, 32'hfff00000, 32'h00200000, 1'b1,
			17'h10000, 32'h00200000},
		// unknown modes give a zero curve
		'{4'd11, 17'h10000, 17'h10000, 32'h12345678, 32'h9abcdef0, 1'b1,
			17'h00000, 32'h12345678},
		'{4'd15, 17'h08000, 17'h00000, 32'h00000000, 32'h00020000, 1'b1,
			17'h08000, 32'h00010000},
		// weight above one on a full curve
		'{MODE_SOFT_OUT, 17'h10000, 17'h1ffff, 32'h00000000, 32'hffff0000, 1'b1,
			17'h10000, 32'hffff0000},
		// every curve mid-range
		'{MODE_EASE_IN, 17'h06000, 17'h10000, 32'h00000000, 32'h00640000, 1'b0, '0, '0},
		'{MODE_EASE_OUT, 17'h06000, 17'h08000, 32'hff9c0000, 32'h00640000, 1'b0, '0, '0},
		'{MODE_FLAT, 17'h06000, 17'h04000, 32'h00000000, 32'h00640000, 1'b0, '0, '0},
		'{MODE_LINEAR, 17'h06000, 17'h0c000, 32'h00640000, 32'h00000000, 1'b0, '0, '0},
		'{MODE_SHARP_IN, 17'h06000, 17'h10000, 32'h00000000, 32'h7fffffff, 1'b0, '0, '0},
		'{MODE_SHARP_OUT, 17'h06000, 17'h10000, 32'h80000000, 32'h7fffffff, 1'b0, '0, '0},
		'{MODE_SHARP_SMOOTH, 17'h06000, 17'h0ffff, 32'h00000000, 32'h00640000, 1'b0,
			'0, '0},
		'{MODE_SMOOTH, 17'h06000, 17'h10000, 32'h00010000, 32'hfffe0000, 1'b0, '0, '0},
		'{MODE_SOFT_IN, 17'h06000, 17'h00001, 32'h00000000, 32'h00640000, 1'b0, '0, '0},
		'{MODE_SOFT_OUT, 17'h06000, 17'h10000, 32'h7fffffff, 32'h80000000, 1'b0, '0, '0},
		'{MODE_SOFT_SMOOTH, 17'h06000, 17'h10000, 32'h00000000, 32'h00640000, 1'b0,
			'0, '0},
		// two-sided curves right at and just below the half point
		'{MODE_SMOOTH, 17'h08000, 17'h10000, 32'h00000000, 32'h00640000, 1'b0, '0, '0},
		'{MODE_SHARP_SMOOTH, 17'h07fff, 17'h10000, 32'h00030000, 32'h00030000, 1'b0,
			'0, '0}
	};

	logic     clk;
	logic     arst_n = 1'b0;
	logic     push   = 1'b0;
	logic     pop    = 1'b0;
	eci_in_t  item   = '0;
	logic     full;
	logic     empty;
	eci_out_t result;

	eci_out_t pending_results [$];
	int       fault_count = 0;
	int       cycle_count = 0;
	int       snd_idle    = 20;
	int       rcv_idle    = 82;
	bit       hold_req    = 1'b0;

	easing_curve_interpolator_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---- predictor ----------------------------------------------------------

	// u^n, truncating after each multiply
	function automatic logic [63:0] power_trunc(logic [63:0] u, int n);
		logic [63:0] acc;
		acc = u;
		for (int i = 1; i < n; i++)
			acc = (acc * u) >> FRAC_BITS;
		return acc;
	endfunction

	function automatic logic [63:0] ease_in_curve(logic [63:0] t, int n);
		return ONE_Q - power_trunc(ONE_Q - t, n);
	endfunction

	function automatic logic [63:0] two_sided_curve(logic [63:0] t, int n);
		if (t < HALF_Q)
			return power_trunc(t << 1, n) >> 1;
		return ((ONE_Q << 1) - power_trunc((ONE_Q - t) << 1, n)) >> 1;
	endfunction

	function automatic eci_out_t ease_predict(eci_in_t w);
		logic [63:0]        t, wt, c, s, mag, prod;
		logic signed [63:0] x0, x1, diff, r;
		eci_out_t           o;
		t  = 64'(w.position);
		wt = 64'(w.weight);
		if (t > ONE_Q)
			t = ONE_Q;
		if (wt > ONE_Q)
			wt = ONE_Q;
		case (w.mode)
			MODE_EASE_IN:      c = ease_in_curve(t, 4);
			MODE_EASE_OUT:     c = power_trunc(t, 4);
			MODE_FLAT:         c = (t < ONE_Q) ? 64'd0 : ONE_Q;
			MODE_LINEAR:       c = t;
			MODE_SHARP_IN:     c = ease_in_curve(t, 8);
			MODE_SHARP_OUT:    c = power_trunc(t, 6);
			MODE_SHARP_SMOOTH: c = two_sided_curve(t, 6);
			MODE_SMOOTH:       c = two_sided_curve(t, 4);
			MODE_SOFT_IN:      c = ease_in_curve(t, 2);
			MODE_SOFT_OUT:     c = power_trunc(t, 2);
			MODE_SOFT_SMOOTH:  c = two_sided_curve(t, 2);
			default:           c = 64'd0;
		endcase
		// blend toward the curve, rounding the product toward zero
		if (c >= t)
			s = t + (((c - t) * wt) >> FRAC_BITS);
		else
			s = t - (((t - c) * wt) >> FRAC_BITS);
		// interpolate on the magnitude of the exact difference
		x0   = $signed(w.start_value);
		x1   = $signed(w.end_value);
		diff = x1 - x0;
		if (diff >= 0) begin
			mag  = diff;
			prod = (mag * s) >> FRAC_BITS;
			r    = x0 + $signed(prod);
		end else begin
			mag  = -diff;
			prod = (mag * s) >> FRAC_BITS;
			r    = x0 - $signed(prod);
		end
		o.shaped_position = s[POS_W-1:0];
		o.result_value    = r[VALUE_WIDTH-1:0];
		return o;
	endfunction

	// ---- checking -----------------------------------------------------------

	task automatic report_mismatch(string msg);
		$display("mismatch @%0d: %s", cycle_count, msg);
		fault_count++;
	endtask

	// offer one word, hold it until accepted, then queue its prediction
	task automatic send_word(eci_in_t w, eci_out_t want);
		while ($urandom_range(0, 99) < snd_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pending_results.push_back(want);
	endtask

	// receiver: check what was popped at this edge, then pick the next pop
	initial begin : receiver
		eci_out_t want;
		int       hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result word %h with nothing pending",
						result));
				end else begin
					want = pending_results.pop_front();
					if (result.shaped_position !== want.shaped_position)
						report_mismatch($sformatf("shaped_position %h, predicted %h",
							result.shaped_position, want.shaped_position));
					if (result.result_value !== want.result_value)
						report_mismatch($sformatf("result_value %h, predicted %h",
							result.result_value, want.result_value));
				end
			end
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= rcv_idle);
			end
		end
	end

	// cycle count and run limit
	initial begin : watchdog
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("[easing_curve_interpolator_top] ERROR");
				$finish;
			end
		end
	end

	// ---- stimulus -----------------------------------------------------------

	initial begin : stimulus
		eci_in_t  w;
		eci_out_t want;
		int       pick;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table
		foreach (dir_tab[i]) begin
			w.mode        = dir_tab[i].mode;
			w.position    = dir_tab[i].pos;
			w.weight      = dir_tab[i].wt;
			w.start_value = dir_tab[i].x0;
			w.end_value   = dir_tab[i].x1;
			if (dir_tab[i].known) begin
				want.shaped_position = dir_tab[i].sp;
				want.result_value    = dir_tab[i].rv;
			end else begin
				want = ease_predict(w);
			end
			send_word(w, want);
		end

		// random words over three pacing phases
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin snd_idle = 20; rcv_idle = 82; end
				1: begin snd_idle = 82; rcv_idle = 20; end
				default: begin
					snd_idle = 0;
					rcv_idle = 0;
					// long receiver stall so both queues fill and full rises
					hold_req = 1'b1;
				end
			endcase
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				// mostly known curves, some unknown modes
				if ($urandom_range(0, 19) < 3)
					w.mode = 4'($urandom_range(11, 15));
				else
					w.mode = 4'($urandom_range(0, 10));
				pick = $urandom_range(0, 15);
				case (pick)
					0:       w.position = '0;
					1:       w.position = ONE;
					2:       w.position = ONE + 17'($urandom_range(1, 65535));
					3:       w.position = HALF - 17'($urandom_range(0, 1));
					default: w.position = 17'($urandom_range(0, 65536));
				endcase
				// about half are unweighted calls
				pick = $urandom_range(0, 15);
				if (pick < 8)
					w.weight = ONE;
				else if (pick == 8)
					w.weight = '0;
				else if (pick == 9)
					w.weight = ONE + 17'($urandom_range(1, 65535));
				else
					w.weight = 17'($urandom_range(0, 65536));
				w.start_value = $urandom;
				pick = $urandom_range(0, 3);
				if (pick == 0)
					w.end_value = w.start_value;
				else if (pick == 1)
					w.end_value = w.start_value + 32'($urandom_range(0, 20'hfffff))
						- 32'h00080000;
				else
					w.end_value = $urandom;
				send_word(w, ease_predict(w));
			end
		end
		push <= 1'b0;

		// drain
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("[easing_curve_interpolator_top] OK");
		else
			$display("[easing_curve_interpolator_top] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
src/eci_pkg.sv
src/eci_front.sv
src/eci_back.sv
src/eci_outq.sv
src/easing_curve_interpolator_top.sv
tb/testbench.sv
